// File: src/btpc_pkg.sv
// Package for the barometric temperature/pressure compensation pipeline.
// Holds the transaction payload types and fixed constants; depends on nothing.
package btpc_pkg;

    // Fixed constants of the integer compensation scheme
    localparam logic signed [32:0] C_TFINE_OFFSET = 33'sd128000;
    localparam logic [20:0]        C_PRESS_BASE   = 21'd1048576;
    localparam logic [63:0]        C_PRESS_SCALE  = 64'd3125;
    localparam logic [31:0]        C_TEMP_ROUND   = 32'd128;
    localparam logic [63:0]        C_X1_BIAS      = 64'h0000_8000_0000_0000;

    // Pipeline geometry
    localparam int C_DIV_N       = 64;  // one quotient bit per divider stage
    localparam int C_FRONT_N     = 9;   // stages ahead of the divider
    localparam int C_BACK_N      = 5;   // quotient sign fix plus four stages
    localparam int C_PIPE_DEPTH  = C_FRONT_N + C_DIV_N + 1 + C_BACK_N;

    // Register indexes on the configuration port
    localparam logic [1:0] C_REG_CAL_TEMP    = 2'd0;
    localparam logic [1:0] C_REG_CAL_PRESS_A = 2'd1;
    localparam logic [1:0] C_REG_CAL_PRESS_B = 2'd2;
    localparam logic [1:0] C_REG_CAL_PRESS_C = 2'd3;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic [31:0]        press_q24_8;
        logic               div_zero;
    } t_out_item;

    // Side data that rides along the divider stages
    typedef struct packed {
        logic [31:0] temp;
        logic        neg;
        logic        dz;
    } t_div_side;

endpackage

// File: src/baro_temp_pressure_compensation.sv
// Top level of the barometric temperature/pressure compensation pipeline.
// Depends on btpc_pkg for payload types and constants.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one raw
//   temperature and raw pressure conversion pair per transaction. Output
//   channel (o_out_valid / i_out_ready / o_out_data) returns the temperature
//   in 0.01 degC, the pressure in Q24.8 pascals saturated to 32 bits, and a
//   flag that marks a zero pressure divisor (pressure then reads 0).
//   Calibration words are written over the APB-style port at byte addresses
//   0, 8, 16 and 24 (64-bit data); write them only while the pipeline is idle.
//   Throughput: one transaction per cycle while o_in_ready is high. A result
//   passes 9 front stages, the divider entry stage, 64 quotient-bit stages,
//   the sign fix and 4 correction stages, then the output register.
//   Stages hold a few parallel multiplies of up to 64x16, 33x33 or 64-bit by a constant, or adds.
//   Reset clears all valid bits and the calibration registers to zero.
//   When the receiver stalls, a finished result waits in the output register
//   and the next one drops into a skid register; only then does o_in_ready
//   fall and the whole pipeline hold, so nothing is lost or repeated.
module baro_temp_pressure_compensation (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  btpc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output btpc_pkg::t_out_item o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    localparam int DEPTH = btpc_pkg::C_PIPE_DEPTH;
    localparam int DN    = btpc_pkg::C_DIV_N;

    // Low 64 bits of a 64-bit word times a signed 16-bit word
    function automatic logic [63:0] f_mul_s16(input logic [63:0] a, input logic [15:0] b);
        logic signed [79:0] prod;
        prod = $signed(a) * $signed(b);
        return prod[63:0];
    endfunction

    // Low 64 bits of a 64-bit word times an unsigned 16-bit word
    function automatic logic [63:0] f_mul_u16(input logic [63:0] a, input logic [15:0] b);
        logic signed [80:0] prod;
        prod = $signed(a) * $signed({1'b0, b});
        return prod[63:0];
    endfunction

    //------------------------------------------------------------------
    // Calibration registers
    //------------------------------------------------------------------
    logic [47:0] r_cal_temp;
    logic [63:0] r_cal_press_a;
    logic [63:0] r_cal_press_b;
    logic [15:0] r_cal_press_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_temp    <= '0;
            r_cal_press_a <= '0;
            r_cal_press_b <= '0;
            r_cal_press_c <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:3])
                btpc_pkg::C_REG_CAL_TEMP:    r_cal_temp    <= pwdata[47:0];
                btpc_pkg::C_REG_CAL_PRESS_A: r_cal_press_a <= pwdata;
                btpc_pkg::C_REG_CAL_PRESS_B: r_cal_press_b <= pwdata;
                btpc_pkg::C_REG_CAL_PRESS_C: r_cal_press_c <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            btpc_pkg::C_REG_CAL_TEMP:    prdata = {16'd0, r_cal_temp};
            btpc_pkg::C_REG_CAL_PRESS_A: prdata = r_cal_press_a;
            btpc_pkg::C_REG_CAL_PRESS_B: prdata = r_cal_press_b;
            btpc_pkg::C_REG_CAL_PRESS_C: prdata = {48'd0, r_cal_press_c};
            default:                     prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Calibration word fields
    logic [15:0]        w_t1;
    logic signed [15:0] w_t2, w_t3;
    logic [15:0]        w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;

    assign w_t1 = r_cal_temp[15:0];
    assign w_t2 = $signed(r_cal_temp[31:16]);
    assign w_t3 = $signed(r_cal_temp[47:32]);
    assign w_p1 = r_cal_press_a[15:0];
    assign w_p2 = r_cal_press_a[31:16];
    assign w_p3 = r_cal_press_a[47:32];
    assign w_p4 = r_cal_press_a[63:48];
    assign w_p5 = r_cal_press_b[15:0];
    assign w_p6 = r_cal_press_b[31:16];
    assign w_p7 = r_cal_press_b[47:32];
    assign w_p8 = r_cal_press_b[63:48];
    assign w_p9 = r_cal_press_c;

    //------------------------------------------------------------------
    // Pipeline control: one enable for all stages, cleared only while the
    // skid register holds a result.
    //------------------------------------------------------------------
    logic             w_en;
    logic [DEPTH-1:0] r_vld;
    logic             r_skid_vld;

    assign w_en       = !r_skid_vld;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in_valid};
        end
    end

    //------------------------------------------------------------------
    // S1: first temperature products
    //------------------------------------------------------------------
    logic signed [17:0] w_da;
    logic signed [33:0] w_a34;
    logic signed [16:0] w_d;
    logic signed [33:0] w_dd34;
    logic [31:0]        r_s1_a, r_s1_dd;
    logic [19:0]        r_s1_rp;

    assign w_da   = $signed({1'b0, i_in_data.raw_temp[19:3]}) - $signed({1'b0, w_t1, 1'b0});
    assign w_a34  = w_da * w_t2;
    assign w_d    = $signed({1'b0, i_in_data.raw_temp[19:4]}) - $signed({1'b0, w_t1});
    assign w_dd34 = w_d * w_d;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_a  <= w_a34[31:0];
            r_s1_dd <= w_dd34[31:0];
            r_s1_rp <= i_in_data.raw_press;
        end
    end

    // S2: scale the first term, multiply the squared term by T3
    logic signed [31:0] w_v1, w_dds;
    logic signed [47:0] w_m48;
    logic [31:0]        r_s2_v1, r_s2_m;
    logic [19:0]        r_s2_rp;

    assign w_v1  = $signed(r_s1_a) >>> 11;
    assign w_dds = $signed(r_s1_dd) >>> 12;
    assign w_m48 = w_dds * w_t3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_v1 <= w_v1;
            r_s2_m  <= w_m48[31:0];
            r_s2_rp <= r_s1_rp;
        end
    end

    // S3: fine temperature
    logic signed [31:0] w_v2;
    logic [31:0]        r_s3_tf;
    logic [19:0]        r_s3_rp;

    assign w_v2 = $signed(r_s2_m) >>> 14;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_tf <= r_s2_v1 + w_v2;
            r_s3_rp <= r_s2_rp;
        end
    end

    // S4: temperature in hundredths, centered fine temperature
    logic [31:0]        w_tc5;
    logic signed [31:0] w_tc;
    logic signed [32:0] w_x1;
    logic [31:0]        r_s4_tc;
    logic signed [32:0] r_s4_x1;
    logic [19:0]        r_s4_rp;

    assign w_tc5 = (r_s3_tf << 2) + r_s3_tf + btpc_pkg::C_TEMP_ROUND;
    assign w_tc  = $signed(w_tc5) >>> 8;
    assign w_x1  = $signed({r_s3_tf[31], r_s3_tf}) - btpc_pkg::C_TFINE_OFFSET;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_tc <= w_tc;
            r_s4_x1 <= w_x1;
            r_s4_rp <= r_s3_rp;
        end
    end

    // S5: square of x1, x1 times P5 and P2
    logic signed [65:0] w_sq;
    logic signed [48:0] w_x1p5, w_x1p2;
    logic [63:0]        r_s5_sq;
    logic [48:0]        r_s5_x1p5, r_s5_x1p2;
    logic [31:0]        r_s5_tc;
    logic [19:0]        r_s5_rp;

    assign w_sq   = r_s4_x1 * r_s4_x1;
    assign w_x1p5 = r_s4_x1 * $signed(w_p5);
    assign w_x1p2 = r_s4_x1 * $signed(w_p2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_sq   <= w_sq[63:0];
            r_s5_x1p5 <= w_x1p5;
            r_s5_x1p2 <= w_x1p2;
            r_s5_tc   <= r_s4_tc;
            r_s5_rp   <= r_s4_rp;
        end
    end

    // S6: square times P6 and P3
    logic [63:0] r_s6_x2a, r_s6_x1c;
    logic [48:0] r_s6_x1p5, r_s6_x1p2;
    logic [31:0] r_s6_tc;
    logic [19:0] r_s6_rp;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_x2a  <= f_mul_s16(r_s5_sq, w_p6);
            r_s6_x1c  <= f_mul_s16(r_s5_sq, w_p3);
            r_s6_x1p5 <= r_s5_x1p5;
            r_s6_x1p2 <= r_s5_x1p2;
            r_s6_tc   <= r_s5_tc;
            r_s6_rp   <= r_s5_rp;
        end
    end

    // S7: sum the x2 terms and the x1 terms
    logic [63:0] w_x1cs;
    logic [63:0] r_s7_x2, r_s7_x1b;
    logic [31:0] r_s7_tc;
    logic [19:0] r_s7_rp;

    assign w_x1cs = $signed(r_s6_x1c) >>> 8;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_x2  <= r_s6_x2a + ({{15{r_s6_x1p5[48]}}, r_s6_x1p5} << 17)
                        + ({{48{w_p4[15]}}, w_p4} << 35);
            r_s7_x1b <= w_x1cs + ({{15{r_s6_x1p2[48]}}, r_s6_x1p2} << 12);
            r_s7_tc  <= r_s6_tc;
            r_s7_rp  <= r_s6_rp;
        end
    end

    // S8: bias x1, form the raw dividend
    logic [20:0] w_pd;
    logic [63:0] r_s8_x1f, r_s8_num;
    logic [31:0] r_s8_tc;

    assign w_pd = btpc_pkg::C_PRESS_BASE - {1'b0, r_s7_rp};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s8_x1f <= btpc_pkg::C_X1_BIAS + r_s7_x1b;
            r_s8_num <= {12'd0, w_pd, 31'd0} - r_s7_x2;
            r_s8_tc  <= r_s7_tc;
        end
    end

    // S9: divisor times P1, dividend times the scale constant
    logic [63:0] r_s9_x1g, r_s9_num;
    logic [31:0] r_s9_tc;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s9_x1g <= f_mul_u16(r_s8_x1f, w_p1);
            r_s9_num <= r_s8_num * btpc_pkg::C_PRESS_SCALE;
            r_s9_tc  <= r_s8_tc;
        end
    end

    //------------------------------------------------------------------
    // Divider: entry 0 holds magnitudes, entries 1..64 develop one
    // quotient bit each (restoring, dividend shifted in from the top).
    //------------------------------------------------------------------
    logic [63:0]         w_den;
    logic [63:0]         r_dv_rem  [0:DN];
    logic [63:0]         r_dv_num  [0:DN];
    logic [63:0]         r_dv_den  [0:DN];
    btpc_pkg::t_div_side r_dv_side [0:DN];

    assign w_den = $signed(r_s9_x1g) >>> 33;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_rem[0]       <= '0;
            r_dv_num[0]       <= r_s9_num[63] ? (64'd0 - r_s9_num) : r_s9_num;
            r_dv_den[0]       <= w_den[63] ? (64'd0 - w_den) : w_den;
            r_dv_side[0].temp <= r_s9_tc;
            r_dv_side[0].neg  <= r_s9_num[63] ^ w_den[63];
            r_dv_side[0].dz   <= (w_den == 64'd0);
        end
    end

    for (genvar g = 0; g < DN; g++) begin : g_div
        logic [64:0] w_sh, w_diff;
        logic        w_ge;

        assign w_sh   = {r_dv_rem[g], r_dv_num[g][63]};
        assign w_diff = w_sh - {1'b0, r_dv_den[g]};
        assign w_ge   = !w_diff[64];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[g+1]  <= w_ge ? w_diff[63:0] : w_sh[63:0];
                r_dv_num[g+1]  <= {r_dv_num[g][62:0], w_ge};
                r_dv_den[g+1]  <= r_dv_den[g];
                r_dv_side[g+1] <= r_dv_side[g];
            end
        end
    end

    // Q: restore the quotient sign
    logic [63:0] r_q_p;
    logic [31:0] r_q_tc;
    logic        r_q_dz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q_p  <= r_dv_side[DN].neg ? (64'd0 - r_dv_num[DN]) : r_dv_num[DN];
            r_q_tc <= r_dv_side[DN].temp;
            r_q_dz <= r_dv_side[DN].dz;
        end
    end

    //------------------------------------------------------------------
    // Back end: second-order pressure correction
    //------------------------------------------------------------------
    logic [63:0] w_ps;
    logic [63:0] r_e1_p, r_e1_ps, r_e1_p9ps, r_e1_p8p;
    logic [31:0] r_e1_tc;
    logic        r_e1_dz;

    assign w_ps = $signed(r_q_p) >>> 13;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1_p    <= r_q_p;
            r_e1_ps   <= w_ps;
            r_e1_p9ps <= f_mul_s16(w_ps, w_p9);
            r_e1_p8p  <= f_mul_s16(r_q_p, w_p8);
            r_e1_tc   <= r_q_tc;
            r_e1_dz   <= r_q_dz;
        end
    end

    // E2: partial products of (P9 * ps) * ps, scaled P8 term
    logic [31:0] w_a_lo, w_a_hi, w_b_lo, w_b_hi;
    logic [63:0] w_ll;
    logic [63:0] w_y2;
    logic [63:0] r_e2_p, r_e2_ll, r_e2_y2;
    logic [31:0] r_e2_lh, r_e2_hl;
    logic [31:0] r_e2_tc;
    logic        r_e2_dz;

    assign w_a_lo = r_e1_p9ps[31:0];
    assign w_a_hi = r_e1_p9ps[63:32];
    assign w_b_lo = r_e1_ps[31:0];
    assign w_b_hi = r_e1_ps[63:32];
    assign w_ll   = {32'd0, w_a_lo} * {32'd0, w_b_lo};
    assign w_y2   = $signed(r_e1_p8p) >>> 19;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e2_p  <= r_e1_p;
            r_e2_ll <= w_ll;
            r_e2_lh <= w_a_lo * w_b_hi;
            r_e2_hl <= w_a_hi * w_b_lo;
            r_e2_y2 <= w_y2;
            r_e2_tc <= r_e1_tc;
            r_e2_dz <= r_e1_dz;
        end
    end

    // E3: assemble the low 64 bits of the product
    logic [31:0] w_cross;
    logic [63:0] r_e3_p, r_e3_y1, r_e3_y2;
    logic [31:0] r_e3_tc;
    logic        r_e3_dz;

    assign w_cross = r_e2_lh + r_e2_hl;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e3_p  <= r_e2_p;
            r_e3_y1 <= r_e2_ll + {w_cross, 32'd0};
            r_e3_y2 <= r_e2_y2;
            r_e3_tc <= r_e2_tc;
            r_e3_dz <= r_e2_dz;
        end
    end

    // E4: corrected sum
    logic [63:0] w_y1s;
    logic [63:0] r_e4_sum;
    logic [31:0] r_e4_tc;
    logic        r_e4_dz;

    assign w_y1s = $signed(r_e3_y1) >>> 25;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e4_sum <= r_e3_p + w_y1s + r_e3_y2;
            r_e4_tc  <= r_e3_tc;
            r_e4_dz  <= r_e3_dz;
        end
    end

    // Final: add the P7 offset, saturate, force zero on a zero divisor
    logic [63:0]         w_sum8, w_pout;
    logic [31:0]         w_press;
    btpc_pkg::t_out_item w_res;

    assign w_sum8 = $signed(r_e4_sum) >>> 8;
    assign w_pout = w_sum8 + {{44{w_p7[15]}}, w_p7, 4'd0};

    always_comb begin
        priority if (r_e4_dz || w_pout[63]) begin
            w_press = '0;
        end else if (w_pout[62:32] != '0) begin
            w_press = '1;
        end else begin
            w_press = w_pout[31:0];
        end
        w_res.temp_centi  = $signed(r_e4_tc);
        w_res.press_q24_8 = w_press;
        w_res.div_zero    = r_e4_dz;
    end

    //------------------------------------------------------------------
    // Output register and skid register
    //------------------------------------------------------------------
    btpc_pkg::t_out_item r_out, r_skid;
    logic                r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_en && r_vld[DEPTH-1]) begin
            // new result arrives; park it if the current one is stuck
            if (r_out_vld && !i_out_ready) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (r_out_vld && i_out_ready) begin
            r_out_vld  <= r_skid_vld;
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_vld[DEPTH-1]) begin
            if (r_out_vld && !i_out_ready) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end else if (r_out_vld && i_out_ready && r_skid_vld) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: src/btpc_checker.sv
// Port-level checker for the compensation pipeline, bound to its top level.
// Depends on btpc_pkg for the payload types.
module btpc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input btpc_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input btpc_pkg::t_out_item o_out_data
);

    // Hold a stalled result and its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result dropped or changed");

    // Zero divisor forces zero pressure
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.div_zero |-> o_out_data.press_q24_8 == 32'd0)
        else $error("div_zero with nonzero pressure");

    // Reset drops any pending result
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Input backpressure only follows an output stall
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input ready dropped without output stall");

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (.*);
